// ----- hw/rtl/lab_pkg.sv -----
// ----------------------------------------------------------------------------
// Look-at basis package
// Shared types, constants and helpers for the look-at basis pipeline.
// ----------------------------------------------------------------------------
package lab_pkg;

  typedef logic signed [63:0] s64_t;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;
  localparam int NORM_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int FRONT_LAT  = 10;
  localparam int PIPE_LAT   = FRONT_LAT + NORM_LAT;

  localparam logic [61:0] FIT_LIMIT = 62'd1 << 30;
  localparam logic [14:0] ONE_Q14   = 15'd16384;

  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  function automatic logic [6:0] bitlen64(input logic [63:0] v);
    logic [6:0] b;
    b = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        b = 7'(i + 1);
      end
    end
    return b;
  endfunction

endpackage

// ----- hw/rtl/look_at_basis_matrix_top.sv -----
// The block takes one transaction per clock unless the output is stalled,
// and returns one 3x3 basis per transaction; its depth comes mostly from the
// 32-step square root and the 15-step divider in each row normalizer. A
// stalled output holds the whole pipeline; input is ready when output is free.
// ----------------------------------------------------------------------------
// Look-at basis matrix
// Builds side, upright and forward unit rows in Q1.14 from a target and an
// up direction in Q3.12, replacing degenerate inputs on the way.
// ----------------------------------------------------------------------------
module look_at_basis_matrix_top #(
  parameter int IN_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // target_x, target_y, target_z, up_x, up_y, up_z, zero fill
  input  logic [((6 * IN_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // side_x/y/z, upright_x/y/z, forward_x/y/z
  output logic [143:0]                           m_axis_tdata
);
  import lab_pkg::*;

  localparam int W = IN_WIDTH;

  logic adv;
  logic vld [0:PIPE_LAT-1];

  logic signed [W-1:0]   in_t [3];
  logic signed [W-1:0]   in_u [3];
  logic                  t_zero;
  logic                  u_zero;

  logic signed [W-1:0]   p0_t [3];
  logic signed [W-1:0]   p0_u [3];
  logic signed [2*W-1:0] p1_a [3];
  logic signed [2*W-1:0] p1_b [3];
  logic signed [W-1:0]   p1_t [3];
  logic signed [W-1:0]   p1_u [3];
  logic signed [W:0]     p2_t [3];
  logic signed [W:0]     p2_u [3];
  logic signed [31:0]    p3_ts [3];
  logic signed [31:0]    p3_us [3];
  logic signed [W:0]     p3_t [3];
  logic signed [63:0]    p4_a [3];
  logic signed [63:0]    p4_b [3];
  logic signed [31:0]    p4_ts [3];
  logic signed [W:0]     p4_t [3];
  s64_t                  p5_s [3];
  logic signed [31:0]    p5_ts [3];
  logic signed [W:0]     p5_t [3];
  logic [61:0]           p6_m [3];
  logic                  p6_n [3];
  logic [61:0]           p6_top;
  logic [6:0]            p6_b;
  s64_t                  p6_s [3];
  logic signed [31:0]    p6_ts [3];
  logic signed [W:0]     p6_t [3];
  logic signed [31:0]    p7_ss [3];
  s64_t                  p7_s [3];
  logic signed [31:0]    p7_ts [3];
  logic signed [W:0]     p7_t [3];
  logic signed [63:0]    p8_a [3];
  logic signed [63:0]    p8_b [3];
  s64_t                  p8_s [3];
  logic signed [W:0]     p8_t [3];
  s64_t                  p9_s [3];
  s64_t                  p9_r [3];
  s64_t                  p9_f [3];

  logic signed [W:0]     up_fix [3];
  logic signed [31:0]    ts_next [3];
  logic signed [31:0]    us_next [3];
  logic [61:0]           m6_next [3];
  logic [61:0]           top6_next;
  logic signed [31:0]    ss_next [3];

  logic signed [15:0]    q_side [3];
  logic signed [15:0]    q_up [3];
  logic signed [15:0]    q_fwd [3];

  assign adv           = !vld[PIPE_LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[PIPE_LAT-1];
  assign m_axis_tdata  = {q_fwd[2], q_fwd[1], q_fwd[0], q_up[2], q_up[1], q_up[0],
                          q_side[2], q_side[1], q_side[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= s_axis_tvalid;
      for (int i = 1; i < PIPE_LAT; i++) begin
        vld[i] <= vld[i - 1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_t[i] = s_axis_tdata[i * W +: W];
      in_u[i] = s_axis_tdata[(i + 3) * W +: W];
    end
    t_zero = (in_t[0] == '0) && (in_t[1] == '0) && (in_t[2] == '0);
    u_zero = (in_u[0] == '0) && (in_u[1] == '0) && (in_u[2] == '0);
  end

  always_comb begin
    if ((p1_a[0] != p1_b[0]) || (p1_a[1] != p1_b[1]) || (p1_a[2] != p1_b[2])) begin
      for (int i = 0; i < 3; i++) begin
        up_fix[i] = (W + 1)'(p1_u[i]);
      end
    end else if ((p1_t[1] != '0) || (p1_t[2] != '0)) begin
      up_fix[0] = '0;
      up_fix[1] = (W + 1)'(p1_t[2]);
      up_fix[2] = -((W + 1)'(p1_t[1]));
    end else begin
      up_fix[0] = '0;
      up_fix[1] = -((W + 1)'(p1_t[0]));
      up_fix[2] = '0;
    end
  end

  always_comb begin
    logic signed [32:0] xt [3];
    logic signed [32:0] xu [3];
    logic [32:0]        mt [3];
    logic [32:0]        mu [3];
    logic               bt;
    logic               bu;
    bt = 1'b0;
    bu = 1'b0;
    for (int i = 0; i < 3; i++) begin
      xt[i] = 33'(p2_t[i]);
      xu[i] = 33'(p2_u[i]);
      mt[i] = xt[i][32] ? 33'(-xt[i]) : 33'(xt[i]);
      mu[i] = xu[i][32] ? 33'(-xu[i]) : 33'(xu[i]);
      bt = bt || (mt[i] > 33'(FIT_LIMIT));
      bu = bu || (mu[i] > 33'(FIT_LIMIT));
    end
    for (int i = 0; i < 3; i++) begin
      ts_next[i] = xt[i][32] ? -32'(bt ? mt[i] >> 1 : mt[i]) : 32'(bt ? mt[i] >> 1 : mt[i]);
      us_next[i] = xu[i][32] ? -32'(bu ? mu[i] >> 1 : mu[i]) : 32'(bu ? mu[i] >> 1 : mu[i]);
    end
  end

  always_comb begin
    logic [63:0] mg;
    top6_next = '0;
    for (int i = 0; i < 3; i++) begin
      mg = p5_s[i][63] ? 64'(-p5_s[i]) : 64'(p5_s[i]);
      m6_next[i] = mg[61:0];
      if (mg[61:0] > top6_next) begin
        top6_next = mg[61:0];
      end
    end
  end

  always_comb begin
    logic [5:0]  rs;
    logic        keep;
    logic [61:0] sh;
    logic [30:0] val;
    rs   = 6'(p6_b - 7'd31);
    keep = (p6_top >> rs) == FIT_LIMIT;
    for (int i = 0; i < 3; i++) begin
      sh = p6_m[i] >> rs;
      if (p6_b >= 7'd31) begin
        val = keep ? sh[30:0] : sh[31:1];
      end else begin
        val = p6_m[i][30:0];
      end
      ss_next[i] = p6_n[i] ? -32'(val) : 32'(val);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (t_zero) begin
          p0_t[i] <= (i == 2) ? W'(1) : '0;
        end else begin
          p0_t[i] <= in_t[i];
        end
        if (u_zero) begin
          p0_u[i] <= (i == 1) ? W'(1) : '0;
        end else begin
          p0_u[i] <= in_u[i];
        end
        p1_a[i]  <= p0_u[NXT[i]] * p0_t[PRV[i]];
        p1_b[i]  <= p0_u[PRV[i]] * p0_t[NXT[i]];
        p1_t[i]  <= p0_t[i];
        p1_u[i]  <= p0_u[i];
        p2_t[i]  <= (W + 1)'(p1_t[i]);
        p2_u[i]  <= up_fix[i];
        p3_ts[i] <= ts_next[i];
        p3_us[i] <= us_next[i];
        p3_t[i]  <= p2_t[i];
        p4_a[i]  <= p3_us[NXT[i]] * p3_ts[PRV[i]];
        p4_b[i]  <= p3_us[PRV[i]] * p3_ts[NXT[i]];
        p4_ts[i] <= p3_ts[i];
        p4_t[i]  <= p3_t[i];
        p5_s[i]  <= p4_a[i] - p4_b[i];
        p5_ts[i] <= p4_ts[i];
        p5_t[i]  <= p4_t[i];
        p6_m[i]  <= m6_next[i];
        p6_n[i]  <= p5_s[i][63];
        p6_s[i]  <= p5_s[i];
        p6_ts[i] <= p5_ts[i];
        p6_t[i]  <= p5_t[i];
        p7_ss[i] <= ss_next[i];
        p7_s[i]  <= p6_s[i];
        p7_ts[i] <= p6_ts[i];
        p7_t[i]  <= p6_t[i];
        p8_a[i]  <= p7_ts[NXT[i]] * p7_ss[PRV[i]];
        p8_b[i]  <= p7_ts[PRV[i]] * p7_ss[NXT[i]];
        p8_s[i]  <= p7_s[i];
        p8_t[i]  <= p7_t[i];
        p9_r[i]  <= p8_a[i] - p8_b[i];
        p9_s[i]  <= p8_s[i];
        p9_f[i]  <= 64'(p8_t[i]);
      end
      p6_top <= top6_next;
      p6_b   <= bitlen64(64'(top6_next));
    end
  end

  lab_norm u_norm_side (
    .clk  (clk),
    .en   (adv),
    .vin  (p9_s),
    .qout (q_side)
  );

  lab_norm u_norm_up (
    .clk  (clk),
    .en   (adv),
    .vin  (p9_r),
    .qout (q_up)
  );

  lab_norm u_norm_fwd (
    .clk  (clk),
    .en   (adv),
    .vin  (p9_f),
    .qout (q_fwd)
  );

`ifndef NO_ASSERTIONS
  a_ready_rule : assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("Input ready does not follow the output stall.");

  a_side_range : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[15:0]) >= -16'sd16384))
    else $error("Side x component is out of the unit range.");

  a_reset_empty : assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Result valid right after reset.");
`endif

endmodule

// ----- hw/rtl/lab_norm.sv -----
// ----------------------------------------------------------------------------
// Look-at basis vector normalizer
// Scales a three-component vector to a Q1.14 unit vector through a range
// shift, a pipelined integer square root and a pipelined restoring divider.
// ----------------------------------------------------------------------------
module lab_norm (
  input  logic               clk,
  input  logic               en,
  input  lab_pkg::s64_t      vin  [3],
  output logic signed [15:0] qout [3]
);
  import lab_pkg::*;

  logic [61:0] mag1 [3];
  logic        neg1 [3];
  logic [61:0] top1;
  logic        zero1;

  logic [61:0] mag2 [3];
  logic        neg2 [3];
  logic [61:0] top2;
  logic [6:0]  b2;
  logic        zero2;

  logic [30:0] m3 [3];
  logic        neg3 [3];
  logic        zero3;

  logic [61:0] sq4 [3];
  logic [30:0] m4 [3];
  logic        neg4 [3];
  logic        zero4;

  logic [63:0] rn [0:SQRT_STEPS];
  logic [63:0] rr [0:SQRT_STEPS];
  logic [30:0] sm [0:SQRT_STEPS][3];
  logic        sneg [0:SQRT_STEPS][3];
  logic        szero [0:SQRT_STEPS];

  logic [45:0] drem [0:DIV_STEPS][3];
  logic [14:0] dq [0:DIV_STEPS][3];
  logic [31:0] dl [0:DIV_STEPS];
  logic        dneg [0:DIV_STEPS][3];
  logic        dzero [0:DIV_STEPS];

  logic [63:0] mag0 [3];
  logic [61:0] top0;
  logic [30:0] m3_next [3];

  always_comb begin
    top0 = '0;
    for (int i = 0; i < 3; i++) begin
      mag0[i] = vin[i][63] ? 64'(-vin[i]) : 64'(vin[i]);
      if (mag0[i][61:0] > top0) begin
        top0 = mag0[i][61:0];
      end
    end
  end

  always_comb begin
    logic [5:0]  rs;
    logic [5:0]  ls;
    logic [61:0] sh;
    logic        keep;
    rs   = 6'(b2 - 7'd31);
    ls   = 6'(7'd31 - b2);
    keep = (b2 >= 7'd31) && ((top2 >> rs) == FIT_LIMIT);
    for (int i = 0; i < 3; i++) begin
      sh = (b2 >= 7'd31) ? (mag2[i] >> rs) : (mag2[i] << ls);
      m3_next[i] = keep ? sh[30:0] : sh[31:1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= mag0[i][61:0];
        neg1[i] <= vin[i][63];
        mag2[i] <= mag1[i];
        neg2[i] <= neg1[i];
        m3[i]   <= m3_next[i];
        neg3[i] <= neg2[i];
        sq4[i]  <= 62'(m3[i]) * 62'(m3[i]);
        m4[i]   <= m3[i];
        neg4[i] <= neg3[i];
        sm[0][i]   <= m4[i];
        sneg[0][i] <= neg4[i];
      end
      top1     <= top0;
      zero1    <= (top0 == '0);
      top2     <= top1;
      b2       <= bitlen64(64'(top1));
      zero2    <= zero1;
      zero3    <= zero2;
      zero4    <= zero3;
      rn[0]    <= 64'(sq4[0]) + 64'(sq4[1]) + 64'(sq4[2]);
      rr[0]    <= '0;
      szero[0] <= zero4;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        take;
    assign trial = rr[k] + BIT;
    assign take  = rn[k] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rn[k + 1]    <= take ? rn[k] - trial : rn[k];
        rr[k + 1]    <= take ? (rr[k] >> 1) + BIT : rr[k] >> 1;
        sm[k + 1]    <= sm[k];
        sneg[k + 1]  <= sneg[k];
        szero[k + 1] <= szero[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= (46'(sm[SQRT_STEPS][i]) << 14) + 46'(rr[SQRT_STEPS][31:1]);
        dq[0][i]   <= '0;
        dneg[0][i] <= sneg[SQRT_STEPS][i];
      end
      dl[0]    <= rr[SQRT_STEPS][31:0];
      dzero[0] <= szero[SQRT_STEPS];
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [45:0] dv;
    assign dv = 46'(dl[j]) << (DIV_STEPS - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          drem[j + 1][i] <= (drem[j][i] >= dv) ? drem[j][i] - dv : drem[j][i];
          dq[j + 1][i]   <= {dq[j][i][13:0], drem[j][i] >= dv};
          dneg[j + 1][i] <= dneg[j][i];
        end
        dl[j + 1]    <= dl[j];
        dzero[j + 1] <= dzero[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dzero[DIV_STEPS]) begin
          qout[i] <= '0;
        end else if (dneg[DIV_STEPS][i]) begin
          qout[i] <= -16'((dq[DIV_STEPS][i] > ONE_Q14) ? ONE_Q14 : dq[DIV_STEPS][i]);
        end else begin
          qout[i] <= 16'((dq[DIV_STEPS][i] > ONE_Q14) ? ONE_Q14 : dq[DIV_STEPS][i]);
        end
      end
    end
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// Look-at basis matrix testbench
// Streams target and up vectors through the block and compares every basis
// against a bit-accurate predictor, with directed corner cases, random and
// near-parallel vectors, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = 16;
  localparam int DW = ((6 * IW + 7) / 8) * 8;
  localparam longint FIT = 64'sd1 << 30;
  localparam longint NLOW = 64'sd1 << 29;
  localparam longint Q14 = 64'sd16384;
  localparam int LIMIT = 400000;

  typedef logic signed [IW-1:0] comp_t;
  typedef longint vec_t [3];
  typedef struct {
    comp_t tx, ty, tz, ux, uy, uz;
  } dir_pair_t;
  typedef logic [143:0] basis_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;

  basis_t basis_queue[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int cycles = 0;

  look_at_basis_matrix_top #(.IN_WIDTH(IW)) dut (.*);

  always #2 clk = ~clk;

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint top_mag(vec_t v);
    longint m;
    m = 0;
    for (int i = 0; i < 3; i++) if (absv(v[i]) > m) m = absv(v[i]);
    return m;
  endfunction

  function automatic vec_t fit_range(vec_t v);
    vec_t r;
    int s;
    s = 0;
    while ((top_mag(v) >> s) > FIT) s++;
    for (int i = 0; i < 3; i++) r[i] = v[i] < 0 ? -(absv(v[i]) >> s) : (v[i] >> s);
    return r;
  endfunction

  function automatic vec_t cross3(vec_t a, vec_t b);
    vec_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic bit all_zero(vec_t v);
    return v[0] == 0 && v[1] == 0 && v[2] == 0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [47:0] unit_row(vec_t v);
    logic [47:0] r;
    longint unsigned m[3], top, l2, len, q;
    int rs, ls;
    r = '0;
    top = top_mag(v);
    if (top == 0) return r;
    rs = 0;
    ls = 0;
    while ((top >> rs) > FIT) rs++;
    top >>= rs;
    while ((top << ls) < NLOW) ls++;
    l2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (longint'(absv(v[i])) >> rs) << ls;
      l2 += m[i] * m[i];
    end
    len = int_sqrt(l2);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * Q14 + len / 2) / len;
      if (q > Q14) q = Q14;
      r[16*i +: 16] = v[i] < 0 ? 16'(-longint'(q)) : 16'(q);
    end
    return r;
  endfunction

  function automatic basis_t look_at_basis(dir_pair_t d);
    vec_t t, u, side, upr;
    t = '{longint'(d.tx), longint'(d.ty), longint'(d.tz)};
    u = '{longint'(d.ux), longint'(d.uy), longint'(d.uz)};
    if (all_zero(t)) t = '{0, 0, 1};
    if (all_zero(u)) u = '{0, 1, 0};
    if (all_zero(cross3(u, t))) begin
      u = '{0, t[2], -t[1]};
      if (all_zero(u)) u = '{t[1], -t[0], 0};
    end
    side = cross3(fit_range(u), fit_range(t));
    upr = cross3(fit_range(t), fit_range(side));
    return {unit_row(t), unit_row(upr), unit_row(side)};
  endfunction

  task automatic send_pair(dir_pair_t d);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= DW'({d.uz, d.uy, d.ux, d.tz, d.ty, d.tx});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    basis_queue.push_back(look_at_basis(d));
  endtask

  task automatic send_vecs(longint tx, longint ty, longint tz,
                           longint ux, longint uy, longint uz);
    dir_pair_t d;
    d = '{comp_t'(tx), comp_t'(ty), comp_t'(tz), comp_t'(ux), comp_t'(uy), comp_t'(uz)};
    send_pair(d);
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(5))
      0: return comp_t'($urandom_range(3)) - 2'sd1;
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      2: return comp_t'($urandom_range(255)) - 16'sd128;
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic dir_pair_t rand_pair();
    dir_pair_t d;
    int k;
    d = '{rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    case ($urandom_range(7))
      0: begin
        k = $urandom_range(4) - 2;
        d.ux = comp_t'(d.tx * k);
        d.uy = comp_t'(d.ty * k);
        d.uz = comp_t'(d.tz * k);
      end
      1: begin
        d.ux = d.tx;
        d.uy = d.ty;
        d.uz = d.tz + comp_t'($urandom_range(2)) - 16'sd1;
      end
      2: {d.ux, d.uy, d.uz} = '0;
      3: {d.tx, d.ty, d.tz} = '0;
      default: ;
    endcase
    return d;
  endfunction

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (basis_queue.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_pair(rand_pair());
  endtask

  task automatic test_directed();
    send_vecs(0, 0, 0, 0, 0, 0);
    send_vecs(0, 0, 4096, 0, 4096, 0);
    send_vecs(4096, 0, 0, 0, 0, 0);
    send_vecs(0, 0, 0, 4096, 0, 0);
    send_vecs(0, 0, 0, 0, 7, 0);
    send_vecs(4096, 0, 0, 8192, 0, 0);
    send_vecs(0, 4096, 0, 0, -4096, 0);
    send_vecs(3, 5, -7, -6, -10, 14);
    send_vecs(32767, 32767, 32767, -32768, -32768, -32768);
    send_vecs(-32768, -32768, -32768, 32767, -32768, 32767);
    send_vecs(-32768, 0, 0, 0, 32767, 0);
    send_vecs(32767, -32768, 1, -1, 1, -32768);
    send_vecs(1, 0, 0, 0, 1, 0);
    send_vecs(1, 1, 1, 1, 1, 0);
    send_vecs(-1, -1, -1, 32767, 32767, 32767);
    send_vecs(0, 0, -1, 0, 0, 32767);
    send_vecs(12345, -23456, 4321, -300, 29999, 111);
    wait_drain();
  endtask

  task automatic test_back_pressure();
    hold_cycles = 300;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (230) send_pair(rand_pair());
    wait_drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    basis_t exp_b;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (basis_queue.size() == 0) begin
        $error("unexpected basis %h", m_axis_tdata);
        errors++;
      end else begin
        exp_b = basis_queue.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (exp_b[16*i +: 16] !== m_axis_tdata[16*i +: 16]) begin
            $error("%s_%s expected %0d actual %0d",
                   i < 3 ? "side" : (i < 6 ? "upright" : "forward"),
                   i % 3 == 0 ? "x" : (i % 3 == 1 ? "y" : "z"),
                   $signed(exp_b[16*i +: 16]), $signed(m_axis_tdata[16*i +: 16]));
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    run_random(400, 0, 0);
    run_random(300, 83, 0);
    run_random(300, 0, 83);
    run_random(400, 9, 9);
    test_back_pressure();
    recv_stall_pct = 0;
    repeat (100) @(posedge clk);
    if (errors == 0 && basis_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
